>>> design/bcd_pkg.sv
// shared types and constants of the block change detector
`default_nettype none
package bcd_pkg;

   // pixels per 8x8 block and the index width inside a block
   localparam int unsigned BLK_PIX   = 64;
   localparam int unsigned PIX_W     = 6;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned RGB_W     = 24;
   localparam int unsigned SUM_W     = 16;
   localparam int unsigned BLKNUM_W  = 11;
   localparam int unsigned COUNT_W   = 12;
   localparam int unsigned TOTAL_W   = 13;
   localparam int unsigned SIZE_W    = 6;
   localparam int unsigned THR_W     = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned RSP_USER_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd2;

   // configuration reset values
   localparam logic [SIZE_W-1:0] WIDTH_RST     = 6'd30;
   localparam logic [SIZE_W-1:0] HEIGHT_RST    = 6'd40;
   localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd192;

   // controller to datapath commands
   typedef struct packed {
      logic accept;     // latch pixel, write block buffer, read reference
      logic diff;       // accumulate absolute differences
      logic decide;     // close the block: change decision, map, counters
      logic rd;         // read block buffer at the sweep index
      logic ld;         // write reference, load pixel request if emitting
      logic res_load;   // load the single block request
      logic inc_idx;    // advance the sweep index
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last_pix;     // pixel just accepted closes its block
      logic will_copy;    // block about to close is copied into the reference
      logic emit_pixels;  // closed block sends its 64 pixels
      logic idx_last;     // sweep index is at the last pixel
      logic rsp_taken;    // result request taken this cycle
   } sts_type;

endpackage
`default_nettype wire

>>> design/block_change_detector_top.sv
// block change detector: top level joining sequencer and datapath
// per pixel: reference read, then accumulate; a block's last pixel adds a
//   decision step; no new pixel is taken until the sequencer is idle again
// changed block: 64 requests, each a buffer read, a reference write and load,
//   then a handoff that waits until it is taken; unchanged block: 1 request
// priming frame: buffer-to-reference copy per pixel, then 1 request per block
// reset: synchronous, active high; registers go to 30 x 40 blocks, threshold
//   192, first frame primes; reference memory is not cleared
`default_nettype none
module block_change_detector_top
   import bcd_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 2048
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [RGB_W-1:0]      req_tdata,   // red, green, blue
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // out_red, out_green, out_blue, block_changed, block_number, map_byte,
   // map_byte_valid, changed_blocks, frame_done, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,   // pixel_valid, priming
   output logic                  rsp_tlast,   // last_of_run
   input  wire                   csr_we,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [THR_W-1:0]      csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   bcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bcd_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> design/bcd_ctrl.sv
// sequencer for pixel intake, block decision and result emission
`default_nettype none
module bcd_ctrl
   import bcd_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIFF   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_RD     = 3'd3;
   localparam logic [2:0] S_LD     = 3'd4;
   localparam logic [2:0] S_RES    = 3'd5;
   localparam logic [2:0] S_WT     = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = sts.last_pix ? S_DECIDE : S_IDLE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.will_copy ? S_RD : S_RES;
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_LD;
         end
         S_LD: begin
            cmd.ld = 1'b1;
            if (sts.emit_pixels) begin
               state_in = S_WT;
            end else if (sts.idx_last) begin
               state_in = S_RES;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_RD;
            end
         end
         S_RES: begin
            cmd.res_load = 1'b1;
            state_in     = S_WT;
         end
         S_WT: begin
            if (sts.rsp_taken) begin
               if (!sts.emit_pixels || sts.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.inc_idx = 1'b1;
                  state_in    = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> design/bcd_datapath.sv
// memories, difference accumulator, block bookkeeping and result register
`default_nettype none
module bcd_datapath
   import bcd_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 2048
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [RGB_W-1:0]      req_tdata,
   input  wire                   csr_we,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [THR_W-1:0]      csr_wdata,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int unsigned BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned REF_DEPTH = MAX_BLOCKS * BLK_PIX;
   localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_BLOCKS);
   localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(BLK_PIX - 1);

   // configuration registers
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   logic [THR_W-1:0]  thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         thr_ff    <= THRESHOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_WIDTH:     width_ff  <= csr_wdata[SIZE_W-1:0];
            REG_HEIGHT:    height_ff <= csr_wdata[SIZE_W-1:0];
            REG_THRESHOLD: thr_ff    <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // memories
   logic [RGB_W-1:0] ref_mem [REF_DEPTH];
   logic [RGB_W-1:0] buf_mem [BLK_PIX];
   logic [RGB_W-1:0] ref_q_ff;
   logic [RGB_W-1:0] buf_q_ff;

   // control and payload registers
   logic [PIX_W-1:0]    pix_ff;
   logic                last_pix_ff;
   logic [RGB_W-1:0]    rgb_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [BLK_W-1:0]    blk_ff;
   logic                ref_valid_ff;
   logic [CHAN_W-1:0]   map_acc_ff;
   logic [2:0]          map_pos_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [PIX_W-1:0]    idx_ff;
   logic [BLK_W-1:0]    res_blk_ff;
   logic                res_emit_ff;
   logic                res_prim_ff;
   logic                res_done_ff;
   logic [CHAN_W-1:0]   res_mb_ff;
   logic                res_mbv_ff;
   logic [COUNT_W-1:0]  res_cnt_ff;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic                rsp_last_ff;

   // block decision terms
   logic [SIZE_W-1:0]  wb;
   logic [SIZE_W-1:0]  hb;
   logic [TOTAL_W-1:0] total;
   logic [TOTAL_W-1:0] total_sat;
   logic [TOTAL_W-1:0] blk_next;
   logic               frame_last;
   logic               changed;
   logic [CHAN_W-1:0]  acc_next;
   logic [COUNT_W-1:0] cnt_next;
   logic               map_flush;

   always_comb begin
      wb        = (width_ff == '0) ? SIZE_W'(1) : width_ff;
      hb        = (height_ff == '0) ? SIZE_W'(1) : height_ff;
      total     = TOTAL_W'(wb) * TOTAL_W'(hb);
      total_sat = (total > MAX_TOTAL) ? MAX_TOTAL : total;
      blk_next  = TOTAL_W'(blk_ff) + TOTAL_W'(1);
      frame_last = (blk_next >= total_sat);
      changed   = ref_valid_ff && (sum_ff > thr_ff);
      acc_next  = map_acc_ff | (changed ? (CHAN_W'(1) << map_pos_ff) : '0);
      cnt_next  = count_ff + COUNT_W'(changed);
      map_flush = (map_pos_ff == 3'd7) || frame_last;
   end

   // reference read at pixel intake, write during the copy sweep
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ref_q_ff <= ref_mem[{blk_ff, pix_ff}];
      end
      if (cmd.ld) begin
         ref_mem[{res_blk_ff, idx_ff}] <= buf_q_ff;
      end
   end

   // block buffer write at intake, read during the sweep
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         buf_mem[pix_ff] <= req_tdata;
      end
      if (cmd.rd) begin
         buf_q_ff <= buf_mem[idx_ff];
      end
   end

   // pixel latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rgb_ff <= req_tdata;
      end
   end

   // absolute difference of the three channels
   logic [CHAN_W-1:0] d_r;
   logic [CHAN_W-1:0] d_g;
   logic [CHAN_W-1:0] d_b;
   logic [9:0]        d_sum;

   always_comb begin
      d_r = (rgb_ff[7:0] > ref_q_ff[7:0]) ? rgb_ff[7:0] - ref_q_ff[7:0]
                                          : ref_q_ff[7:0] - rgb_ff[7:0];
      d_g = (rgb_ff[15:8] > ref_q_ff[15:8]) ? rgb_ff[15:8] - ref_q_ff[15:8]
                                             : ref_q_ff[15:8] - rgb_ff[15:8];
      d_b = (rgb_ff[23:16] > ref_q_ff[23:16]) ? rgb_ff[23:16] - ref_q_ff[23:16]
                                               : ref_q_ff[23:16] - rgb_ff[23:16];
      d_sum = 10'(d_r) + 10'(d_g) + 10'(d_b);
   end

   // block state: pixel index, sum, block counter, map and count
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff       <= '0;
         last_pix_ff  <= 1'b0;
         sum_ff       <= '0;
         blk_ff       <= '0;
         ref_valid_ff <= 1'b0;
         map_acc_ff   <= '0;
         map_pos_ff   <= '0;
         count_ff     <= '0;
      end else begin
         if (cmd.accept) begin
            pix_ff      <= pix_ff + PIX_W'(1);
            last_pix_ff <= (pix_ff == PIX_LAST);
         end
         if (cmd.diff && ref_valid_ff) begin
            sum_ff <= sum_ff + SUM_W'(d_sum);
         end
         if (cmd.decide) begin
            sum_ff <= '0;
            blk_ff <= frame_last ? '0 : BLK_W'(blk_next);
            if (!ref_valid_ff) begin
               if (frame_last) begin
                  ref_valid_ff <= 1'b1;
               end
            end else begin
               map_acc_ff <= map_flush ? '0 : acc_next;
               map_pos_ff <= map_flush ? '0 : map_pos_ff + 3'd1;
               count_ff   <= frame_last ? '0 : cnt_next;
            end
         end
      end
   end

   // fields of the closed block, held for emission
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         res_blk_ff  <= blk_ff;
         res_emit_ff <= changed;
         res_prim_ff <= !ref_valid_ff;
         res_done_ff <= frame_last;
         res_mb_ff   <= (ref_valid_ff && map_flush) ? acc_next : '0;
         res_mbv_ff  <= ref_valid_ff && map_flush;
         res_cnt_ff  <= (ref_valid_ff && frame_last) ? cnt_next : '0;
      end
   end

   // sweep index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.decide) begin
         idx_ff <= '0;
      end else if (cmd.inc_idx) begin
         idx_ff <= idx_ff + PIX_W'(1);
      end
   end

   // result request register
   logic idx_last;
   logic fin;
   assign idx_last = (idx_ff == PIX_LAST);
   assign fin      = idx_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load || (cmd.ld && res_emit_ff)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld && res_emit_ff) begin
         rsp_data_ff <= {6'd0, fin & res_done_ff, fin ? res_cnt_ff : COUNT_W'(0),
                         fin & res_mbv_ff, fin ? res_mb_ff : CHAN_W'(0),
                         BLKNUM_W'(res_blk_ff), 1'b1, buf_q_ff};
         rsp_user_ff <= 2'b01;
         rsp_last_ff <= fin;
      end else if (cmd.res_load) begin
         rsp_data_ff <= {6'd0, res_done_ff, res_cnt_ff, res_mbv_ff, res_mb_ff,
                         BLKNUM_W'(res_blk_ff), 1'b0, 24'd0};
         rsp_user_ff <= {res_prim_ff, 1'b0};
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // status to the controller
   always_comb begin
      sts.last_pix    = last_pix_ff;
      sts.will_copy   = changed || !ref_valid_ff;
      sts.emit_pixels = res_emit_ff;
      sts.idx_last    = idx_last;
      sts.rsp_taken   = rsp_valid_ff && rsp_tready;
   end

endmodule
`default_nettype wire
